// ----- hw/rtl/arsm_pkg.sv -----
// arsm_pkg: shared types, command and register codes, reset values
// used by every module of the acknowledge retry / stale monitor
package arsm_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int RETRY_W  = 8;
    localparam int ZONE_W   = 4;
    localparam int ACTION_W = 8;
    localparam int CMD_W    = 3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // event codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUTTON     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POLL_SENT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACK_SENT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FORCE_POLL = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRIES   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_PERIOD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMERG_ZONE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_ACTION    = 3'd5;

    // register reset values
    localparam logic [TIME_W-1:0]   RST_STALE_TIMEOUT = 32'd1000;
    localparam logic [TIME_W-1:0]   RST_RETRY_PERIOD  = 32'd200;
    localparam logic [RETRY_W-1:0]  RST_MAX_RETRIES   = 8'd3;
    localparam logic [TIME_W-1:0]   RST_POLL_PERIOD   = 32'd100;
    localparam logic [ZONE_W-1:0]   RST_EMERG_ZONE    = 4'd3;
    localparam logic [ACTION_W-1:0] RST_ACK_ACTION    = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [TIME_W-1:0]   now_ms;
        logic                emergency_latched;
        logic [ZONE_W-1:0]   zone;
        logic [ACTION_W-1:0] button_action;
    } in_item_t;

    typedef struct packed {
        logic               poll_due;
        logic               ack_due;
        logic               status_fresh;
        logic               emergency_active;
        logic               ack_pending;
        logic               awaiting_clear;
        logic [RETRY_W-1:0] retries;
        logic [COUNT_W-1:0] timeouts;
        logic [COUNT_W-1:0] give_ups;
        logic [COUNT_W-1:0] confirms;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]   stale_timeout_ms;
        logic [TIME_W-1:0]   retry_period_ms;
        logic [RETRY_W-1:0]  max_retries;
        logic [TIME_W-1:0]   poll_period_ms;
        logic [ZONE_W-1:0]   emergency_zone_code;
        logic [ACTION_W-1:0] ack_action_code;
    } cfg_t;

endpackage

// ----- hw/rtl/ack_retry_stale_monitor.sv -----
// ack_retry_stale_monitor: top level, input register, result register, handshakes
// depends on arsm_pkg, arsm_cfg, arsm_core
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    in_data (in_item_t)
// out      out  out_valid / out_ready  out_data (out_item_t)
// cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// one item per clock sustained while out_ready is high; out_valid rises when
// an item leaves the input register; the event update and result are one pass
// through arsm_core between the input register and the result register
// in_ready falls only while both registers hold items and out_ready is low
// reset clears the valid flags and the monitor state; configuration returns to its reset values
module ack_retry_stale_monitor
    import arsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    arsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    arsm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input register empty but not ready");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item lost before result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

// ----- hw/rtl/arsm_cfg.sv -----
// arsm_cfg: configuration register file with write-only port
// depends on arsm_pkg
module arsm_cfg
    import arsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STALE_TIMEOUT: cfg_next.stale_timeout_ms    = cfg_wdata[TIME_W-1:0];
                CFG_RETRY_PERIOD:  cfg_next.retry_period_ms     = cfg_wdata[TIME_W-1:0];
                CFG_MAX_RETRIES:   cfg_next.max_retries         = cfg_wdata[RETRY_W-1:0];
                CFG_POLL_PERIOD:   cfg_next.poll_period_ms      = cfg_wdata[TIME_W-1:0];
                CFG_EMERG_ZONE:    cfg_next.emergency_zone_code = cfg_wdata[ZONE_W-1:0];
                CFG_ACK_ACTION:    cfg_next.ack_action_code     = cfg_wdata[ACTION_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stale_timeout_ms    <= RST_STALE_TIMEOUT;
            cfg_reg.retry_period_ms     <= RST_RETRY_PERIOD;
            cfg_reg.max_retries         <= RST_MAX_RETRIES;
            cfg_reg.poll_period_ms      <= RST_POLL_PERIOD;
            cfg_reg.emergency_zone_code <= RST_EMERG_ZONE;
            cfg_reg.ack_action_code     <= RST_ACK_ACTION;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/arsm_core.sv -----
// arsm_core: monitor state and per-event update, result of the item in flight
// depends on arsm_pkg
module arsm_core
    import arsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic               status_valid_reg, status_valid_next;
    logic               status_stale_reg, status_stale_next;
    logic               held_emergency_reg, held_emergency_next;
    logic [ZONE_W-1:0]  held_zone_reg, held_zone_next;
    logic [TIME_W-1:0]  last_status_time_reg, last_status_time_next;
    logic [TIME_W-1:0]  last_poll_time_reg, last_poll_time_next;
    logic               force_poll_reg, force_poll_next;
    logic               pending_reg, pending_next;
    logic               waiting_clear_reg, waiting_clear_next;
    logic [RETRY_W-1:0] retry_count_reg, retry_count_next;
    logic [TIME_W-1:0]  last_ack_time_reg, last_ack_time_next;
    logic [COUNT_W-1:0] timeout_count_reg, timeout_count_next;
    logic [COUNT_W-1:0] give_up_count_reg, give_up_count_next;
    logic [COUNT_W-1:0] confirm_count_reg, confirm_count_next;

    logic exp_stale;
    logic exp_ack_old;
    logic exp_poll_old;
    logic ack_time_now;
    logic poll_time_now;
    logic exp_ack;
    logic exp_poll;
    logic fresh;
    logic retries_used;

    // wrap-safe expiry against the stored times
    assign exp_stale    = (item.now_ms - last_status_time_reg) >= cfg.stale_timeout_ms;
    assign exp_ack_old  = (item.now_ms - last_ack_time_reg) >= cfg.retry_period_ms;
    assign exp_poll_old = (item.now_ms - last_poll_time_reg) >= cfg.poll_period_ms;

    always_comb
    begin
        status_valid_next     = status_valid_reg;
        status_stale_next     = status_stale_reg;
        held_emergency_next   = held_emergency_reg;
        held_zone_next        = held_zone_reg;
        last_status_time_next = last_status_time_reg;
        last_poll_time_next   = last_poll_time_reg;
        force_poll_next       = force_poll_reg;
        pending_next          = pending_reg;
        waiting_clear_next    = waiting_clear_reg;
        retry_count_next      = retry_count_reg;
        last_ack_time_next    = last_ack_time_reg;
        timeout_count_next    = timeout_count_reg;
        give_up_count_next    = give_up_count_reg;
        confirm_count_next    = confirm_count_reg;
        ack_time_now          = 1'b0;
        poll_time_now         = 1'b0;

        unique case (item.cmd)
            CMD_TICK:
            begin
                if (status_valid_reg && !status_stale_reg && exp_stale)
                begin
                    status_stale_next  = 1'b1;
                    timeout_count_next = timeout_count_reg + COUNT_W'(1);
                end
                if (pending_reg && waiting_clear_reg &&
                    (retry_count_reg >= cfg.max_retries) && exp_ack_old)
                begin
                    pending_next       = 1'b0;
                    waiting_clear_next = 1'b0;
                    give_up_count_next = give_up_count_reg + COUNT_W'(1);
                end
            end
            CMD_STATUS:
            begin
                held_emergency_next   = item.emergency_latched;
                held_zone_next        = item.zone;
                status_valid_next     = 1'b1;
                status_stale_next     = 1'b0;
                last_status_time_next = item.now_ms;
                if (pending_reg && !item.emergency_latched)
                begin
                    pending_next       = 1'b0;
                    waiting_clear_next = 1'b0;
                    retry_count_next   = '0;
                    confirm_count_next = confirm_count_reg + COUNT_W'(1);
                end
            end
            CMD_BUTTON:
            begin
                if (item.button_action == cfg.ack_action_code)
                begin
                    pending_next = 1'b1;
                end
            end
            CMD_POLL_SENT:
            begin
                force_poll_next     = 1'b0;
                last_poll_time_next = item.now_ms;
                poll_time_now       = 1'b1;
            end
            CMD_ACK_SENT:
            begin
                if (waiting_clear_reg)
                begin
                    retry_count_next = retry_count_reg + RETRY_W'(1);
                end
                else
                begin
                    retry_count_next = '0;
                end
                waiting_clear_next = 1'b1;
                last_ack_time_next = item.now_ms;
                ack_time_now       = 1'b1;
            end
            CMD_FORCE_POLL:
            begin
                force_poll_next = 1'b1;
            end
            default:
            begin
                force_poll_next = force_poll_reg;
            end
        endcase

        // a time just stamped with now_ms has zero elapsed time
        exp_ack      = ack_time_now ? (cfg.retry_period_ms == '0) : exp_ack_old;
        exp_poll     = poll_time_now ? (cfg.poll_period_ms == '0) : exp_poll_old;
        fresh        = status_valid_next && !status_stale_next;
        retries_used = retry_count_next >= cfg.max_retries;

        result.poll_due         = force_poll_next || exp_poll;
        result.ack_due          = pending_next && fresh && held_emergency_next &&
                                  (held_zone_next != cfg.emergency_zone_code) &&
                                  (!waiting_clear_next || (!retries_used && exp_ack));
        result.status_fresh     = fresh;
        result.emergency_active = fresh && held_emergency_next;
        result.ack_pending      = pending_next;
        result.awaiting_clear   = waiting_clear_next;
        result.retries          = retry_count_next;
        result.timeouts         = timeout_count_next;
        result.give_ups         = give_up_count_next;
        result.confirms         = confirm_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg     <= 1'b0;
            status_stale_reg     <= 1'b0;
            held_emergency_reg   <= 1'b0;
            held_zone_reg        <= '0;
            last_status_time_reg <= '0;
            last_poll_time_reg   <= '0;
            force_poll_reg       <= 1'b0;
            pending_reg          <= 1'b0;
            waiting_clear_reg    <= 1'b0;
            retry_count_reg      <= '0;
            last_ack_time_reg    <= '0;
            timeout_count_reg    <= '0;
            give_up_count_reg    <= '0;
            confirm_count_reg    <= '0;
        end
        else if (fire)
        begin
            status_valid_reg     <= status_valid_next;
            status_stale_reg     <= status_stale_next;
            held_emergency_reg   <= held_emergency_next;
            held_zone_reg        <= held_zone_next;
            last_status_time_reg <= last_status_time_next;
            last_poll_time_reg   <= last_poll_time_next;
            force_poll_reg       <= force_poll_next;
            pending_reg          <= pending_next;
            waiting_clear_reg    <= waiting_clear_next;
            retry_count_reg      <= retry_count_next;
            last_ack_time_reg    <= last_ack_time_next;
            timeout_count_reg    <= timeout_count_next;
            give_up_count_reg    <= give_up_count_next;
            confirm_count_reg    <= confirm_count_next;
        end
    end

    a_stale_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        status_stale_reg |-> status_valid_reg)
        else $error("stale flag set without valid status");

    a_confirm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.cmd == CMD_STATUS) && !item.emergency_latched && pending_reg
        |=> !pending_reg && (retry_count_reg == '0))
        else $error("clean status did not clear pending acknowledge");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(timeout_count_reg) && $stable(give_up_count_reg) &&
                  $stable(confirm_count_reg))
        else $error("event counter moved without an item");

    a_ack_due_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        result.ack_due |-> result.ack_pending && result.status_fresh)
        else $error("ack due without pending request and fresh status");

endmodule

// ----- tb/tb_ack_retry_stale_monitor.sv -----
// tb_ack_retry_stale_monitor: self-checking bench for the acknowledge retry / stale monitor
// a scoreboard class mirrors the event state and checks every result item in order
// depends on arsm_pkg and ack_retry_stale_monitor
module tb_ack_retry_stale_monitor;
    import arsm_pkg::*;

    // commands with no event behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
    localparam int MAX_SHOWN = 100;

    class sensor_ack_shadow;
        cfg_t                cfg;
        logic                have_status;
        logic                went_stale;
        logic                emerg_held;
        logic [ZONE_W-1:0]   zone_held;
        logic [TIME_W-1:0]   status_at;
        logic [TIME_W-1:0]   polled_at;
        logic [TIME_W-1:0]   acked_at;
        logic                poll_forced;
        logic                ack_wanted;
        logic                ack_waiting;
        logic [RETRY_W-1:0]  retry_cnt;
        logic [COUNT_W-1:0]  stale_cnt;
        logic [COUNT_W-1:0]  give_up_cnt;
        logic [COUNT_W-1:0]  confirm_cnt;
        out_item_t           awaited[$];
        int                  mismatch_count;
        int                  result_idx;

        function new();
            cfg.stale_timeout_ms    = RST_STALE_TIMEOUT;
            cfg.retry_period_ms     = RST_RETRY_PERIOD;
            cfg.max_retries         = RST_MAX_RETRIES;
            cfg.poll_period_ms      = RST_POLL_PERIOD;
            cfg.emergency_zone_code = RST_EMERG_ZONE;
            cfg.ack_action_code     = RST_ACK_ACTION;
            have_status    = 1'b0;
            went_stale     = 1'b0;
            emerg_held     = 1'b0;
            zone_held      = '0;
            status_at      = '0;
            polled_at      = '0;
            acked_at       = '0;
            poll_forced    = 1'b0;
            ack_wanted     = 1'b0;
            ack_waiting    = 1'b0;
            retry_cnt      = '0;
            stale_cnt      = '0;
            give_up_cnt    = '0;
            confirm_cnt    = '0;
            mismatch_count = 0;
            result_idx     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_STALE_TIMEOUT: cfg.stale_timeout_ms    = val;
                CFG_RETRY_PERIOD:  cfg.retry_period_ms     = val;
                CFG_MAX_RETRIES:   cfg.max_retries         = val[RETRY_W-1:0];
                CFG_POLL_PERIOD:   cfg.poll_period_ms      = val;
                CFG_EMERG_ZONE:    cfg.emergency_zone_code = val[ZONE_W-1:0];
                CFG_ACK_ACTION:    cfg.ack_action_code     = val[ACTION_W-1:0];
                default: ;
            endcase
        endfunction

        // wrap-safe expiry on 32-bit times
        function logic elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                               logic [TIME_W-1:0] period);
            logic [TIME_W-1:0] diff;
            diff = now - since;
            return diff >= period;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void apply_event(in_item_t ev);
            out_item_t r;
            logic      fresh;
            logic      ack;
            case (ev.cmd)
                CMD_TICK:
                begin
                    if (have_status && !went_stale &&
                        elapsed(ev.now_ms, status_at, cfg.stale_timeout_ms))
                    begin
                        went_stale = 1'b1;
                        stale_cnt  = stale_cnt + 1'b1;
                    end
                    if (ack_wanted && ack_waiting && retry_cnt >= cfg.max_retries &&
                        elapsed(ev.now_ms, acked_at, cfg.retry_period_ms))
                    begin
                        ack_wanted  = 1'b0;
                        ack_waiting = 1'b0;
                        give_up_cnt = give_up_cnt + 1'b1;
                    end
                end
                CMD_STATUS:
                begin
                    emerg_held  = ev.emergency_latched;
                    zone_held   = ev.zone;
                    have_status = 1'b1;
                    went_stale  = 1'b0;
                    status_at   = ev.now_ms;
                    if (ack_wanted && !ev.emergency_latched)
                    begin
                        ack_wanted  = 1'b0;
                        ack_waiting = 1'b0;
                        retry_cnt   = '0;
                        confirm_cnt = confirm_cnt + 1'b1;
                    end
                end
                CMD_BUTTON:
                begin
                    if (ev.button_action == cfg.ack_action_code)
                        ack_wanted = 1'b1;
                end
                CMD_POLL_SENT:
                begin
                    poll_forced = 1'b0;
                    polled_at   = ev.now_ms;
                end
                CMD_ACK_SENT:
                begin
                    if (ack_waiting)
                        retry_cnt = retry_cnt + 1'b1;
                    else
                        retry_cnt = '0;
                    ack_waiting = 1'b1;
                    acked_at    = ev.now_ms;
                end
                CMD_FORCE_POLL:
                    poll_forced = 1'b1;
                default: ;
            endcase

            fresh = have_status && !went_stale;
            if (!ack_wanted || !fresh || !emerg_held || zone_held == cfg.emergency_zone_code)
                ack = 1'b0;
            else if (!ack_waiting)
                ack = 1'b1;
            else if (retry_cnt >= cfg.max_retries)
                ack = 1'b0;
            else
                ack = elapsed(ev.now_ms, acked_at, cfg.retry_period_ms);

            r.poll_due         = poll_forced || elapsed(ev.now_ms, polled_at, cfg.poll_period_ms);
            r.ack_due          = ack;
            r.status_fresh     = fresh;
            r.emergency_active = fresh && emerg_held;
            r.ack_pending      = ack_wanted;
            r.awaiting_clear   = ack_waiting;
            r.retries          = retry_cnt;
            r.timeouts         = stale_cnt;
            r.give_ups         = give_up_cnt;
            r.confirms         = confirm_cnt;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("result %0d %s: expected 0x%0h, got 0x%0h",
                         result_idx, field, want, got);
        endtask

        task compare_report(out_item_t got);
            out_item_t want;
            result_idx++;
            if (awaited.size() == 0)
            begin
                report_mismatch("unexpected item", 32'd0, 32'd1);
                return;
            end
            want = awaited.pop_front();
            if (got.poll_due !== want.poll_due)
                report_mismatch("poll_due", want.poll_due, got.poll_due);
            if (got.ack_due !== want.ack_due)
                report_mismatch("ack_due", want.ack_due, got.ack_due);
            if (got.status_fresh !== want.status_fresh)
                report_mismatch("status_fresh", want.status_fresh, got.status_fresh);
            if (got.emergency_active !== want.emergency_active)
                report_mismatch("emergency_active", want.emergency_active, got.emergency_active);
            if (got.ack_pending !== want.ack_pending)
                report_mismatch("ack_pending", want.ack_pending, got.ack_pending);
            if (got.awaiting_clear !== want.awaiting_clear)
                report_mismatch("awaiting_clear", want.awaiting_clear, got.awaiting_clear);
            if (got.retries !== want.retries)
                report_mismatch("retries", want.retries, got.retries);
            if (got.timeouts !== want.timeouts)
                report_mismatch("timeouts", want.timeouts, got.timeouts);
            if (got.give_ups !== want.give_ups)
                report_mismatch("give_ups", want.give_ups, got.give_ups);
            if (got.confirms !== want.confirms)
                report_mismatch("confirms", want.confirms, got.confirms);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    sensor_ack_shadow  shadow = new();
    logic [TIME_W-1:0] clock_ms;
    int                events_sent;
    logic              tx_idle_on;
    logic              rx_idle_on;

    ack_retry_stale_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls on out_ready
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap();
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (out_valid && out_ready)
            shadow.compare_report(out_data);

    task automatic send(input in_item_t ev);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        shadow.apply_event(ev);
        events_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // hold off new items until every result is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        shadow.set_reg(idx, val);
    endtask

    // narrow registers get random upper bits
    task automatic load_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] w;
        put_reg(CFG_STALE_TIMEOUT, c.stale_timeout_ms);
        put_reg(CFG_RETRY_PERIOD, c.retry_period_ms);
        w = $urandom();
        w[RETRY_W-1:0] = c.max_retries;
        put_reg(CFG_MAX_RETRIES, w);
        put_reg(CFG_POLL_PERIOD, c.poll_period_ms);
        w = $urandom();
        w[ZONE_W-1:0] = c.emergency_zone_code;
        put_reg(CFG_EMERG_ZONE, w);
        w = $urandom();
        w[ACTION_W-1:0] = c.ack_action_code;
        put_reg(CFG_ACK_ACTION, w);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t random_item(logic [CMD_W-1:0] cmd);
        in_item_t ev;
        ev = {$urandom(), $urandom()};
        ev.cmd    = cmd;
        ev.now_ms = clock_ms;
        return ev;
    endfunction

    function automatic logic [ZONE_W-1:0] open_zone();
        logic [ZONE_W-1:0] z;
        z = $urandom();
        if (z == shadow.cfg.emergency_zone_code)
            z = z + 1'b1;
        return z;
    endfunction

    function automatic logic [TIME_W-1:0] time_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 50);
        if (r < 85)
            return $urandom_range(0, 400);
        if (r < 95)
            return $urandom_range(0, 3000);
        if (r < 98)
            return '1;
        return $urandom();
    endfunction

    // lands on, just before or just after the retry boundary half the time
    function automatic logic [TIME_W-1:0] retry_step();
        if ($urandom_range(0, 1) == 0)
            return shadow.cfg.retry_period_ms + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 600);
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                            input logic em, input logic [ZONE_W-1:0] z,
                            input logic [ACTION_W-1:0] act);
        in_item_t ev;
        clock_ms             = now;
        ev.cmd               = cmd;
        ev.now_ms            = now;
        ev.emergency_latched = em;
        ev.zone              = z;
        ev.button_action     = act;
        send(ev);
    endtask

    task automatic directed_run();
        send_cmd(CMD_TICK,       32'd0,    1'b0, 4'd0,  8'd0);
        send_cmd(CMD_FORCE_POLL, 32'd10,   1'b0, 4'd0,  8'd0);
        send_cmd(CMD_POLL_SENT,  32'd20,   1'b0, 4'd0,  8'd0);
        send_cmd(CMD_STATUS,     32'd30,   1'b1, 4'd5,  8'd0);
        send_cmd(CMD_BUTTON,     32'd40,   1'b0, 4'd0,  8'hFF);
        send_cmd(CMD_BUTTON,     32'd50,   1'b0, 4'd0,  8'd1);
        send_cmd(CMD_ACK_SENT,   32'd60,   1'b0, 4'd0,  8'd0);
        send_cmd(CMD_TICK,       32'd270,  1'b0, 4'd0,  8'd0);
        send_cmd(CMD_ACK_SENT,   32'd270,  1'b0, 4'd0,  8'd0);
        send_cmd(CMD_ACK_SENT,   32'd480,  1'b0, 4'd0,  8'd0);
        send_cmd(CMD_ACK_SENT,   32'd690,  1'b0, 4'd0,  8'd0);
        // retries used up, next expiry gives up
        send_cmd(CMD_TICK,       32'd900,  1'b0, 4'd0,  8'd0);
        send_cmd(CMD_TICK,       32'd2000, 1'b0, 4'd0,  8'd0);
        send_cmd(CMD_BUTTON,     32'd2010, 1'b1, 4'd15, 8'd1);
        send_cmd(CMD_STATUS,     32'd2020, 1'b0, 4'd15, 8'd0);
        send_cmd(CMD_BUTTON,     32'd2030, 1'b0, 4'd0,  8'd1);
        // emergency zone blocks the acknowledge
        send_cmd(CMD_STATUS,     32'd2040, 1'b1, 4'd3,  8'd0);
        send_cmd(CMD_SPARE_A,    32'hFFFF_FFFF, 1'b1, 4'd15, 8'hFF);
        send_cmd(CMD_SPARE_B,    32'hFFFF_FF00, 1'b1, 4'd15, 8'hFF);
        // time wraps past zero
        send_cmd(CMD_STATUS,     32'hFFFF_FFF0, 1'b1, 4'd0, 8'd0);
        send_cmd(CMD_TICK,       32'h0000_0010, 1'b0, 4'd0, 8'd0);
        send_cmd(CMD_ACK_SENT,   32'h0000_0020, 1'b0, 4'd0, 8'd0);
        send_cmd(CMD_POLL_SENT,  32'hFFFF_FFFF, 1'b0, 4'd0, 8'd0);
        send_cmd(CMD_TICK,       32'h0000_0062, 1'b0, 4'd0, 8'd0);
        send_cmd(CMD_TICK,       32'h0000_0063, 1'b0, 4'd0, 8'd0);
    endtask

    task automatic random_event();
        in_item_t         ev;
        int               r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 30)
            cmd = CMD_TICK;
        else if (r < 45)
            cmd = CMD_STATUS;
        else if (r < 60)
            cmd = CMD_BUTTON;
        else if (r < 70)
            cmd = CMD_POLL_SENT;
        else if (r < 84)
            cmd = CMD_ACK_SENT;
        else if (r < 94)
            cmd = CMD_FORCE_POLL;
        else if (r < 97)
            cmd = CMD_SPARE_A;
        else
            cmd = CMD_SPARE_B;
        clock_ms = clock_ms + time_step();
        ev = random_item(cmd);
        if ($urandom_range(0, 1) == 0)
            ev.zone = shadow.cfg.emergency_zone_code;
        if ($urandom_range(0, 9) < 6)
            ev.button_action = shadow.cfg.ack_action_code;
        if ($urandom_range(0, 99) < 3)
            ev.now_ms = $urandom();
        send(ev);
    endtask

    // button, emergency status, acknowledges and retries, then clean status, emergency status or stale tick
    task automatic ack_exchange();
        in_item_t ev;
        int       rounds;
        int       k;
        ev = random_item(CMD_BUTTON);
        ev.button_action = shadow.cfg.ack_action_code;
        send(ev);
        clock_ms = clock_ms + $urandom_range(0, 50);
        ev = random_item(CMD_STATUS);
        ev.emergency_latched = 1'b1;
        ev.zone = ($urandom_range(0, 9) == 0) ? shadow.cfg.emergency_zone_code : open_zone();
        send(ev);
        rounds = $urandom_range(1, 6);
        for (k = 0; k < rounds; k++)
        begin
            clock_ms = clock_ms + $urandom_range(0, 20);
            send(random_item(CMD_ACK_SENT));
            clock_ms = clock_ms + retry_step();
            send(random_item(CMD_TICK));
            if ($urandom_range(0, 3) == 0)
                send(random_item($urandom_range(0, 1) ? CMD_POLL_SENT : CMD_FORCE_POLL));
        end
        case ($urandom_range(0, 2))
            0:
            begin
                ev = random_item(CMD_STATUS);
                ev.emergency_latched = 1'b0;
                send(ev);
            end
            1:
            begin
                ev = random_item(CMD_STATUS);
                ev.emergency_latched = 1'b1;
                send(ev);
            end
            default:
            begin
                clock_ms = clock_ms + shadow.cfg.stale_timeout_ms + $urandom_range(0, 2) - 1;
                send(random_item(CMD_TICK));
            end
        endcase
    endtask

    task automatic random_phase(input int count);
        int  target;
        bit  paused;
        target = events_sent + count;
        paused = 1'b0;
        while (events_sent < target)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (!paused && events_sent >= target - count / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
                random_event();
            else
                ack_exchange();
        end
    endtask

    // acknowledges back to back so the retry count wraps
    task automatic retry_storm();
        in_item_t ev;
        int       k;
        ev = random_item(CMD_BUTTON);
        ev.button_action = shadow.cfg.ack_action_code;
        send(ev);
        ev = random_item(CMD_STATUS);
        ev.emergency_latched = 1'b1;
        ev.zone = open_zone();
        send(ev);
        for (k = 0; k < 260; k++)
        begin
            clock_ms = clock_ms + retry_step();
            send(random_item(CMD_ACK_SENT));
        end
    endtask

    function automatic cfg_t moderate_cfg();
        cfg_t c;
        c.stale_timeout_ms    = $urandom_range(1, 2000);
        c.retry_period_ms     = $urandom_range(1, 500);
        c.max_retries         = $urandom_range(0, 6);
        c.poll_period_ms      = $urandom_range(1, 300);
        c.emergency_zone_code = $urandom();
        c.ack_action_code     = $urandom();
        return c;
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        clock_ms    = '0;
        events_sent = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_run();
        random_phase(120);

        settle();
        load_config('0);
        random_phase(120);

        settle();
        load_config('1);
        retry_storm();
        random_phase(120);

        repeat (2)
        begin
            settle();
            load_config(moderate_cfg());
            random_phase(120);
        end

        settle();
        repeat (10) @(posedge clk);

        if (shadow.mismatch_count == 0 && shadow.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/arsm_pkg.sv
hw/rtl/arsm_cfg.sv
hw/rtl/arsm_core.sv
hw/rtl/ack_retry_stale_monitor.sv
tb/tb_ack_retry_stale_monitor.sv
